/* src/ordered_unique_set_store_assert.svh */
// Assertion macros used by the ordered unique set store top level.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ORDERED_UNIQUE_SET_STORE_ASSERT_SVH
`define ORDERED_UNIQUE_SET_STORE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define OUSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define OUSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* src/ouss_pkg.sv */
// Package of the ordered unique set store: codes, widths, the request token type
// and the key mask function. Used by ouss_cell and ordered_unique_set_store.
`timescale 1ns / 1ps

package ouss_pkg;

	localparam int KEY_W        = 64;
	localparam int CFG_W        = 4;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;
	localparam logic [CFG_W-1:0] ELEM_SIZE_RESET = 4'd4;

	// Operation selector on the input tuser.
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_ADDED    = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_REMOVED  = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	// Request token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic    act;    // token present
		logic    fin;    // outcome settled, token only travels to the end
		logic    fnd;    // a matching entry was seen in an earlier cell
		logic    op;     // OP_ADD or OP_REMOVE
		status_t status; // outcome once fin is set
	} tok_t;

	// Byte mask of the element: size zero counts as one byte, above eight as eight.
	function automatic logic [KEY_W-1:0] key_mask(input logic [CFG_W-1:0] size);
		logic [CFG_W-1:0] n;
		logic [KEY_W-1:0] m;
		n = (size == '0) ? CFG_W'(1) : size;
		for (int b = 0; b < KEY_W / 8; b++) begin
			m[b*8 +: 8] = (CFG_W'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

/* src/ouss_cell.sv */
// One storage cell of the ordered unique set store: one entry plus the token stage.
// Depends on ouss_pkg.
`timescale 1ns / 1ps

module ouss_cell import ouss_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX      = 0,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,     // entries held before this request
	input  logic [KEY_W-1:0] key,       // masked request key
	input  logic [KEY_W-1:0] mask,      // element byte mask
	input  tok_t             tok_in,    // token from the cell before
	output tok_t             tok_out,   // token after this cell has worked on it
	input  logic [KEY_W-1:0] nxt_entry, // entry of the cell after, for closing a gap
	output logic [KEY_W-1:0] entry
);

	localparam bit IS_LAST = (IDX == CAPACITY - 1);

	tok_t             tok_q;
	logic [KEY_W-1:0] entry_q;
	logic             valid;
	logic             hit;
	logic             found;
	logic             wr;
	logic [KEY_W-1:0] wdata;

	assign entry = entry_q;

	// The cell holds a live entry when its place is below the count.
	assign valid = (count > CNT_W'(IDX));
	assign hit   = valid && (((entry_q ^ key) & mask) == '0);
	assign found = tok_q.fnd || hit;

	// Work on the token held in this cell.
	always_comb begin
		tok_out = tok_q;
		wr      = 1'b0;
		wdata   = key;
		if (tok_q.act && !tok_q.fin) begin
			if (!valid) begin
				// First empty place: append on add, end of search on remove.
				tok_out.fin = 1'b1;
				if (tok_q.op == OP_ADD) begin
					wr             = 1'b1;
					tok_out.status = STAT_ADDED;
				end else begin
					tok_out.status = tok_q.fnd ? STAT_REMOVED : STAT_NOTFOUND;
				end
			end else if (tok_q.op == OP_ADD) begin
				if (hit) begin
					tok_out.fin    = 1'b1;
					tok_out.status = STAT_PRESENT;
				end else if (IS_LAST) begin
					tok_out.fin    = 1'b1;
					tok_out.status = STAT_FULL;
				end
			end else begin
				// From the match onward every entry takes its neighbor's value.
				tok_out.fnd = found;
				if (found) begin
					wr    = 1'b1;
					wdata = nxt_entry;
				end
				if (IS_LAST) begin
					tok_out.fin    = 1'b1;
					tok_out.status = found ? STAT_REMOVED : STAT_NOTFOUND;
				end
			end
		end
	end

	// Token stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= wdata;
		end
	end

endmodule

/* src/ordered_unique_set_store.sv */
// Top level of the ordered unique set store: request intake, row of cells,
// count and result register. Depends on ouss_pkg, ouss_cell and the assert header.
`timescale 1ns / 1ps
`include "ordered_unique_set_store_assert.svh"

// Usage
// Requests arrive on the s_ channel: s_tuser is the operation (0 add, 1 remove)
// and s_tdata the 64-bit key. Results leave on the m_ channel: m_tuser is the
// status (0 added, 1 already present, 2 removed, 3 not found, 4 full) and
// m_tdata holds the count after the request. The element size in bytes is
// written on the cfg_ channel, which is always ready; write it only while idle.
// A request travels as a token through the CAPACITY cells, one cell per cycle;
// m_tvalid rises once its outcome is loaded into the output register. One request
// is in work at a time: a new beat is taken only once the last result is in the output register.
// A remove shifts the later entries forward as the token passes them.
// Reset empties the store and sets the element size to four bytes; the entries
// themselves need no clearing pass.
// The result sits in an output register; if the receiver stalls, a finished
// result waits in a hold stage and no new request is taken until it moves on.
// A new request is taken while an earlier result still waits on m_.
module ordered_unique_set_store import ouss_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,   // elem_size_bytes
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [KEY_W-1:0] s_tdata,    // key[63:0]
	input  logic             s_tuser,    // op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,    // count[6:0], zero pad bit 7
	output logic [2:0]       m_tuser     // status[2:0]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_RUN  = 3'b010,
		FSM_HOLD = 3'b100
	} fsm_t;

	fsm_t             fsm_q;
	logic [CFG_W-1:0] cfg_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] mask_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	status_t          hold_status_q;
	logic [CNT_W-1:0] hold_count_q;
	logic             m_tvalid_q;
	status_t          out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	tok_t             tok_chain [CAPACITY+1];
	logic [KEY_W-1:0] ent_chain [CAPACITY+1];
	tok_t             res;
	logic             accept;
	logic             out_free;
	logic             res_fire;
	logic             res_add;
	logic             out_load;
	status_t          load_status;
	logic [CNT_W-1:0] load_count;
	logic [CNT_W+COUNT_W-1:0] load_count_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (fsm_q == FSM_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {1'b0, out_count_q};

	// Element size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ELEM_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// Masked key and mask, held steady while the token walks.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= s_tdata & key_mask(cfg_q);
			mask_q <= key_mask(cfg_q);
		end
	end

	// Token injected into the first cell on an accepted beat.
	always_comb begin
		tok_chain[0]        = '0;
		tok_chain[0].act    = accept;
		tok_chain[0].op     = s_tuser;
		tok_chain[0].status = STAT_ADDED;
	end

	assign ent_chain[CAPACITY] = '0;

	// Row of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ouss_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count_q),
			.key       (key_q),
			.mask      (mask_q),
			.tok_in    (tok_chain[i]),
			.tok_out   (tok_chain[i+1]),
			.nxt_entry (ent_chain[i+1]),
			.entry     (ent_chain[i])
		);
	end

	// Outcome leaving the last cell and the count it leads to.
	assign res      = tok_chain[CAPACITY];
	assign res_fire = res.act && (fsm_q == FSM_RUN);
	assign res_add  = res_fire && (res.status == STAT_ADDED);

	always_comb begin
		count_nxt = count_q;
		if (res.status == STAT_ADDED) begin
			count_nxt = CNT_W'(count_q + 1'b1);
		end else if (res.status == STAT_REMOVED) begin
			count_nxt = CNT_W'(count_q - 1'b1);
		end
	end

	// Output register loads from the live outcome or from the hold stage.
	assign out_free       = !m_tvalid_q || m_tready;
	assign out_load       = out_free && (res_fire || (fsm_q == FSM_HOLD));
	assign load_status    = (fsm_q == FSM_HOLD) ? hold_status_q : res.status;
	assign load_count     = (fsm_q == FSM_HOLD) ? hold_count_q : count_nxt;
	assign load_count_ext = {{COUNT_W{1'b0}}, load_count};

	// Sequencer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= FSM_IDLE;
			count_q <= '0;
		end else begin
			case (fsm_q)
				FSM_IDLE: begin
					if (accept) begin
						fsm_q <= FSM_RUN;
					end
				end
				FSM_RUN: begin
					if (res_fire) begin
						count_q <= count_nxt;
						fsm_q   <= out_free ? FSM_IDLE : FSM_HOLD;
					end
				end
				FSM_HOLD: begin
					if (out_free) begin
						fsm_q <= FSM_IDLE;
					end
				end
				default: begin
					fsm_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// Hold stage for a result that finds the output register busy.
	always_ff @(posedge clk) begin
		if (res_fire) begin
			hold_status_q <= res.status;
			hold_count_q  <= count_nxt;
		end
	end

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= load_status;
			out_count_q  <= load_count_ext[COUNT_W-1:0];
		end
	end

	// Checks on the sequencer and the count.
	`OUSS_ASSERT(a_count_cap, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`OUSS_ASSERT(a_res_in_run, !res.act || (fsm_q == FSM_RUN), "token left the row while not running")
	`OUSS_ASSERT_NEXT(a_add_count, res_add, count_q == CNT_W'($past(count_q) + 1'b1), "add did not raise count")

endmodule

/* tb/ordered_unique_set_store_tb.sv */
// Self-checking testbench for the ordered unique set store: drives add and remove
// requests on the stream input, predicts each status and count, and checks them.
// Depends on ouss_pkg and ordered_unique_set_store.
`timescale 1ns / 1ps

module ordered_unique_set_store_tb;
	import ouss_pkg::*;

	localparam int STORE_DEPTH    = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	// Expected outcome of one request.
	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  count;
	} outcome_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [KEY_W-1:0] s_tdata   = '0;      // key[63:0]
	logic             s_tuser   = OP_ADD;  // op
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;             // count[6:0], pad bit 7
	logic [2:0]       m_tuser;             // status[2:0]

	// Shadow copy of the store contents and its element size register.
	logic [KEY_W-1:0] held_keys [STORE_DEPTH];
	int               held_count;
	logic [CFG_W-1:0] elem_size;

	outcome_t expected_outcomes [$];
	outcome_t head_outcome;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_request;
	int hold_left;
	int stall_cycles;
	int requests_sent;
	int results_seen;
	int outcome_errors;
	int full_reports;
	int shift_removes;

	ordered_unique_set_store #(
		.CAPACITY(STORE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Byte mask of one element; size zero means one byte, eight and above all bytes.
	function automatic logic [KEY_W-1:0] elem_mask(input logic [CFG_W-1:0] size);
		int nbytes;
		nbytes = (size == '0) ? 1 : int'(size);
		if (nbytes >= 8) begin
			return '1;
		end
		return (64'd1 << (8 * nbytes)) - 64'd1;
	endfunction

	// Applies one request to the shadow store and returns its status and count.
	function automatic outcome_t apply_set_request(input logic op, input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] mask;
		logic [KEY_W-1:0] masked_key;
		int               hit;
		outcome_t         res;
		mask       = elem_mask(elem_size);
		masked_key = key & mask;
		hit        = -1;
		// The first match in insertion order wins.
		for (int i = 0; i < held_count; i++) begin
			if (hit < 0 && ((held_keys[i] ^ masked_key) & mask) == '0) begin
				hit = i;
			end
		end
		if (op == OP_ADD) begin
			if (hit >= 0) begin
				res.status = STAT_PRESENT;
			end else if (held_count >= STORE_DEPTH) begin
				res.status = STAT_FULL;
				full_reports++;
			end else begin
				held_keys[held_count] = masked_key;
				held_count++;
				res.status = STAT_ADDED;
			end
		end else begin
			if (hit < 0) begin
				res.status = STAT_NOTFOUND;
			end else begin
				// Close the gap by moving every later entry forward.
				for (int j = hit; j < held_count - 1; j++) begin
					held_keys[j] = held_keys[j + 1];
				end
				if (hit < held_count - 1) begin
					shift_removes++;
				end
				held_count--;
				res.status = STAT_REMOVED;
			end
		end
		res.count = COUNT_W'(held_count);
		return res;
	endfunction

	function automatic void note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		outcome_errors++;
		if (outcome_errors <= MAX_REPORTS) begin
			$display("Mismatch at result %0d: %s, expected %0h, got %0h",
				results_seen, what, want, got);
		end
	endfunction

	// Sends one request beat and records its predicted outcome once accepted.
	task automatic send_request(input logic op, input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		expected_outcomes.push_back(apply_set_request(op, key));
		requests_sent++;
	endtask

	// Stops offering requests until every pending result has been delivered.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	// Writes the element size while the store is idle.
	task automatic write_elem_size(input logic [CFG_W-1:0] size);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		elem_size = size;
	endtask

	// Random requests; hits reuse a held key with the unused upper bytes scrambled.
	task automatic send_random_requests(input int n_items, input int add_pct, input int hit_pct);
		logic             op;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] mask;
		for (int i = 0; i < n_items; i++) begin
			op   = ($urandom_range(99) < add_pct) ? OP_ADD : OP_REMOVE;
			mask = elem_mask(elem_size);
			key  = {$urandom, $urandom};
			if (held_count > 0 && $urandom_range(99) < hit_pct) begin
				key = (held_keys[$urandom_range(held_count - 1)] & mask) | (key & ~mask);
			end
			send_request(op, key);
		end
	endtask

	// Key extremes, both operations, and the element size corner cases.
	task automatic test_directed_cases();
		send_request(OP_ADD,    64'h0000_0000_0000_0000);
		send_request(OP_ADD,    64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_ADD,    64'hABCD_0000_0000_0000);
		send_request(OP_REMOVE, 64'h1234_0000_FFFF_FFFF);
		send_request(OP_REMOVE, 64'h0000_0000_0000_0005);
		send_request(OP_ADD,    64'h0000_0000_1122_3344);
		send_request(OP_ADD,    64'h0000_0000_5566_7788);
		send_request(OP_REMOVE, 64'h0000_0000_0000_0000);
		send_request(OP_REMOVE, 64'hFFFF_0000_5566_7788);
		send_request(OP_REMOVE, 64'h0000_0000_1122_3344);
		send_request(OP_REMOVE, 64'h0000_0000_0000_0000);
		// Size zero compares a single byte.
		write_elem_size(4'd0);
		send_request(OP_ADD,    64'h0000_0000_0000_0100);
		send_request(OP_ADD,    64'h0000_0000_0000_0200);
		send_request(OP_REMOVE, 64'h0000_0000_0000_FF00);
		// Sizes above eight compare all eight bytes.
		write_elem_size(4'd15);
		send_request(OP_ADD,    64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_ADD,    64'h7FFF_FFFF_FFFF_FFFF);
		send_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF);
		// Narrowing the size while entries are held: the first match is removed.
		write_elem_size(4'd8);
		send_request(OP_ADD,    64'h1111_2222_3333_4444);
		send_request(OP_ADD,    64'h5555_2222_3333_4444);
		write_elem_size(4'd4);
		send_request(OP_REMOVE, 64'h9999_9999_3333_4444);
		write_elem_size(4'd8);
		send_request(OP_REMOVE, 64'h5555_2222_3333_4444);
	endtask

	// Fills the store, then checks the full and already-present outcomes at capacity.
	task automatic test_fill_to_capacity();
		write_elem_size(4'd2);
		for (int i = 0; i < STORE_DEPTH; i++) begin
			send_request(OP_ADD, {$urandom, 16'($urandom), 16'(i * 37 + 1)});
		end
		send_request(OP_ADD,    held_keys[5] | {$urandom, 16'($urandom), 16'h0});
		send_request(OP_ADD,    64'h0000_0000_0000_FFFF);
		send_request(OP_REMOVE, held_keys[0]);
		send_request(OP_ADD,    64'h0000_0000_0000_FFFF);
		send_request(OP_ADD,    64'h0000_0000_0000_FFFE);
		send_request(OP_REMOVE, held_keys[STORE_DEPTH - 1]);
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		wait_results_drained();
		hold_request = 400;
		send_random_requests(8, 60, 50);
		wait_results_drained();
	endtask

	// Random traffic across idle patterns and element sizes.
	task automatic test_random_traffic();
		send_idle_pct = 10;
		recv_idle_pct = 88;
		write_elem_size(4'd4);
		send_random_requests(150, 65, 50);
		write_elem_size(4'd1);
		send_random_requests(120, 80, 30);

		send_idle_pct = 88;
		recv_idle_pct = 10;
		write_elem_size(4'd8);
		send_random_requests(120, 60, 50);
		write_elem_size(4'd3);
		send_random_requests(80, 55, 60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_elem_size(4'd0);
		send_random_requests(80, 75, 40);
		write_elem_size(4'd11);
		send_random_requests(60, 60, 50);
		write_elem_size(4'd2);
		send_random_requests(50, 70, 40);
		write_elem_size(4'd6);
		send_random_requests(50, 50, 60);
	endtask

	// Result receiver; a requested hold-off is counted down here.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compares each delivered result beat with the oldest expected outcome.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				note_mismatch("result with nothing pending", '0, 64'({m_tuser, m_tdata}));
			end else begin
				head_outcome = expected_outcomes.pop_front();
				if (m_tuser !== head_outcome.status) begin
					note_mismatch("status", 64'(head_outcome.status), 64'(m_tuser));
				end
				if (m_tdata[COUNT_W-1:0] !== head_outcome.count) begin
					note_mismatch("count", 64'(head_outcome.count),
						64'(m_tdata[COUNT_W-1:0]));
				end
				if (m_tdata[7] !== 1'b0) begin
					note_mismatch("count pad bit", '0, 64'(m_tdata[7]));
				end
			end
		end
	end

	// Watchdog: ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		held_count    = 0;
		elem_size     = ELEM_SIZE_RESET;
		send_idle_pct = 10;
		recv_idle_pct = 88;
		hold_request  = 0;
		hold_left     = 0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fill_to_capacity();
		test_output_backpressure();
		test_random_traffic();

		wait_results_drained();
		repeat (STORE_DEPTH + 10) @(posedge clk);
		if (expected_outcomes.size() != 0) begin
			note_mismatch("results never delivered", 64'(expected_outcomes.size()), '0);
		end

		$display("Ran %0d add and remove requests over element sizes 0 to 15; %0d results checked.",
			requests_sent, results_seen);
		$display("Store refused adds at capacity %0d times; %0d removes shifted later entries.",
			full_reports, shift_removes);
		if (outcome_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
